### rtl/bpbe_pkg.sv
// shared types and constants of the block projection bit extractor
// no dependencies; used by bpbe_colsum, the top level and the testbench

package bpbe_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_BLOCK_MODE   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_index_t;

	localparam int CFG_DATA_W = 13;
	localparam int SUM_W      = 11;
	localparam int WGT_W      = 14;
	localparam int PROD_W     = WGT_W + SUM_W + 1;
	localparam int ACC_W      = 28;

	localparam logic [11:0] WIDTH_RESET  = 12'd1920;
	localparam logic [12:0] HEIGHT_RESET = 13'd1080;
	localparam logic [12:0] MAX_HEIGHT   = 13'd4096;

	// first-cosine weights, 13 fractional bits
	localparam logic signed [WGT_W-1:0] WEIGHTS8 [8] = '{
		14'sd8035, 14'sd6811, 14'sd4551, 14'sd1598,
		-14'sd1598, -14'sd4551, -14'sd6811, -14'sd8035
	};
	localparam logic signed [WGT_W-1:0] WEIGHTS4 [4] = '{
		14'sd7568, 14'sd3135, -14'sd3135, -14'sd7568
	};

	// request into the column sum memory
	typedef struct packed {
		logic en;
		logic first_row;
	} colsum_req_t;

	function automatic logic signed [WGT_W-1:0] weight(input logic mode, input logic [2:0] xr);
		logic signed [WGT_W-1:0] w;
		if (mode) begin
			w = WEIGHTS4[xr[1:0]];
		end else begin
			w = WEIGHTS8[xr];
		end
		return w;
	endfunction

endpackage

### rtl/bpbe_colsum.sv
// column sum memory with read-modify-write: read on the request beat,
// add and write back in the next cycle; uses bpbe_pkg

module bpbe_colsum #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpbe_pkg::colsum_req_t          req,
	input  logic [$clog2(MAX_WIDTH)-1:0]   addr,
	input  logic [7:0]                     pixel,
	output logic [bpbe_pkg::SUM_W-1:0]     sum
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [bpbe_pkg::SUM_W-1:0] mem [MAX_WIDTH];
	logic [bpbe_pkg::SUM_W-1:0] rd_data_s1;
	logic [CW-1:0]              addr_s1;
	logic [7:0]                 pixel_s1;
	logic                       first_s1;
	logic                       vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			rd_data_s1 <= mem[addr];
			addr_s1    <= addr;
			pixel_s1   <= pixel;
			first_s1   <= req.first_row;
		end
	end

	// first row of a block row starts the sum over
	assign sum = first_s1 ? {3'b000, pixel_s1} : rd_data_s1 + {3'b000, pixel_s1};

	// the same column does not come back before its write-back, so no forwarding
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem[addr_s1] <= sum;
		end
	end

endmodule

### rtl/block_projection_bit_extractor.sv
// top level of the block projection bit extractor
// uses bpbe_pkg and bpbe_colsum

// Takes one pixel per clock in raster order while pixel_stall is low and gives
// one byte for every eight finished blocks (8x8 or 4x4 by block_mode), first
// block in the MSB; frame_last marks the frame's final full byte. Column sums
// sit in one MAX_WIDTH-entry memory that is read on the pixel beat and written
// back in the next cycle; a byte's last pixel passes the stage 1 and stage 2
// registers before the byte enters the output buffer. Bytes wait in a two-entry
// output buffer, and pixel_stall rises only while both entries are full.

module block_projection_bit_extractor #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  pixel,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  data_byte,
	output logic        frame_last
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WEW  = (CW + 1 > 12) ? CW + 1 : 12;
	localparam int BPRW = WEW - 2;
	localparam int TW   = BPRW + 11;

	// configuration
	logic        mode_q;
	logic [11:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= bpbe_pkg::WIDTH_RESET;
			height_q <= bpbe_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bpbe_pkg::REG_BLOCK_MODE:   mode_q   <= cfg_data[0];
				bpbe_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[11:0];
				bpbe_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame geometry
	logic [WEW-1:0]  iw_ext;
	logic [WEW-1:0]  weff;
	logic [WEW-1:0]  wfull;
	logic [12:0]     heff;
	logic [12:0]     hfull;
	logic [BPRW-1:0] bpr;
	logic [10:0]     brows;
	logic [TW-1:0]   total_q;

	always_comb begin
		iw_ext = WEW'(width_q);
		weff   = (iw_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : iw_ext;
		if (weff == '0) begin
			weff = WEW'(1);
		end
		heff = (height_q > bpbe_pkg::MAX_HEIGHT) ? bpbe_pkg::MAX_HEIGHT : height_q;
		if (heff == '0) begin
			heff = 13'd1;
		end
		if (mode_q) begin
			wfull = {weff[WEW-1:2], 2'b00};
			hfull = {heff[12:2], 2'b00};
			bpr   = weff[WEW-1:2];
			brows = heff[12:2];
		end else begin
			wfull = {weff[WEW-1:3], 3'b000};
			hfull = {heff[12:3], 3'b000};
			bpr   = {1'b0, weff[WEW-1:3]};
			brows = {1'b0, heff[12:3]};
		end
	end

	// frame block count, stable with items in flight if user holds config
	always_ff @(posedge clk) begin
		total_q <= TW'(bpr * brows);
	end

	// pixel position
	logic [CW-1:0] x_q;
	logic [11:0]   y_q;
	logic          accept;
	logic          col_end;
	logic          row_end;
	logic          act;
	logic          first_row;
	logic          last_row;
	logic          last_col;
	logic [CW-1:0] bcol;
	logic [9:0]    brow;

	assign accept  = pixel_valid && !pixel_stall;
	assign col_end = (WEW'(x_q) + WEW'(1)) >= weff;
	assign row_end = (13'(y_q) + 13'd1) >= heff;
	assign act     = (WEW'(x_q) < wfull) && (13'(y_q) < hfull);

	always_comb begin
		if (mode_q) begin
			first_row = (y_q[1:0] == 2'd0);
			last_row  = (y_q[1:0] == 2'd3);
			last_col  = (x_q[1:0] == 2'd3);
			bcol      = x_q >> 2;
			brow      = y_q[11:2];
		end else begin
			first_row = (y_q[2:0] == 3'd0);
			last_row  = (y_q[2:0] == 3'd7);
			last_col  = (x_q[2:0] == 3'd7);
			bcol      = x_q >> 3;
			brow      = {1'b0, y_q[11:3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				x_q <= '0;
				y_q <= row_end ? 12'd0 : y_q + 12'd1;
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	// column sums
	bpbe_pkg::colsum_req_t      cs_req;
	logic [bpbe_pkg::SUM_W-1:0] sum;

	assign cs_req.en        = accept && act;
	assign cs_req.first_row = first_row;

	bpbe_colsum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_colsum (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cs_req),
		.addr   (x_q),
		.pixel  (pixel),
		.sum    (sum)
	);

	// stage 1: weighting and block index
	logic          v_s1;
	logic          acc_en_s1;
	logic          blk_done_s1;
	logic          frame_end_s1;
	logic [2:0]    xr_s1;
	logic [CW-1:0] bcol_s1;
	logic [9:0]    brow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_en_s1    <= act && last_row;
			blk_done_s1  <= act && last_row && last_col;
			frame_end_s1 <= col_end && row_end;
			xr_s1        <= x_q[2:0];
			bcol_s1      <= bcol;
			brow_s1      <= brow;
		end
	end

	// stage 2: accumulate and pack
	logic                                v_s2;
	logic                                acc_en_s2;
	logic                                blk_done_s2;
	logic                                frame_end_s2;
	logic signed [bpbe_pkg::PROD_W-1:0]  prod_s2;
	logic [CW-1:0]                       bcol_s2;
	logic [BPRW+9:0]                     base_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_en_s2    <= acc_en_s1;
			blk_done_s2  <= blk_done_s1;
			frame_end_s2 <= frame_end_s1;
			prod_s2      <= bpbe_pkg::weight(mode_q, xr_s1) * $signed({1'b0, sum});
			bcol_s2      <= bcol_s1;
			base_s2      <= brow_s1 * bpr;
		end
	end

	logic [bpbe_pkg::ACC_W-1:0] acc_q;
	logic [7:0]                 shift_q;
	logic [2:0]                 nbits_q;
	logic [bpbe_pkg::ACC_W-1:0] acc_sum;
	logic                       blk_bit;
	logic                       push;
	logic [7:0]                 new_byte;
	logic                       new_last;
	logic [TW:0]                bidx9;

	assign acc_sum  = acc_q + bpbe_pkg::ACC_W'(prod_s2);
	assign blk_bit  = (acc_sum != '0) && !acc_sum[bpbe_pkg::ACC_W-1];
	assign push     = v_s2 && acc_en_s2 && blk_done_s2 && (nbits_q == 3'd7);
	assign new_byte = {shift_q[6:0], blk_bit};
	assign bidx9    = (TW+1)'(base_s2) + (TW+1)'(bcol_s2) + (TW+1)'(9);
	assign new_last = bidx9 > {1'b0, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			shift_q <= '0;
			nbits_q <= '0;
		end else if (v_s2) begin
			if (frame_end_s2) begin
				acc_q   <= '0;
				shift_q <= '0;
				nbits_q <= '0;
			end else if (acc_en_s2) begin
				if (blk_done_s2) begin
					acc_q   <= '0;
					shift_q <= push ? 8'd0 : new_byte;
					nbits_q <= nbits_q + 3'd1;
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	// two-entry output buffer; bytes are at least eight finished blocks apart
	logic [1:0] cnt_q;
	logic [7:0] byte1_q;
	logic       last1_q;
	logic       pop;

	assign pop         = byte_valid && !byte_stall;
	assign pixel_stall = (cnt_q == 2'd2);
	assign byte_valid  = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				data_byte  <= new_byte;
				frame_last <= new_last;
			end else begin
				data_byte  <= byte1_q;
				frame_last <= last1_q;
			end
			if (push) begin
				byte1_q <= new_byte;
				last1_q <= new_last;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				data_byte  <= new_byte;
				frame_last <= new_last;
			end else begin
				byte1_q <= new_byte;
				last1_q <= new_last;
			end
		end
	end

endmodule

### rtl/bpbe_checker.sv
// port-level checks of the block projection bit extractor, bound to the top level
// depends on block_projection_bit_extractor's ports only

module bpbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_valid,
	input logic       pixel_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] data_byte,
	input logic       frame_last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(data_byte) && $stable(frame_last))
		else $error("stalled output beat changed");

	// input is held back only while a byte waits
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> byte_valid)
		else $error("pixel stall without a waiting byte");

	// a fresh byte shows only after the accepted pixel that finished it
	a_rise_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_valid) |-> $past(pixel_valid && !pixel_stall, 3))
		else $error("byte appeared without a pixel beat three cycles before");

	// stall releases only when a byte is taken
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pixel_stall) |-> $past(byte_valid && !byte_stall))
		else $error("pixel stall released without an output beat");

endmodule

bind block_projection_bit_extractor bpbe_checker u_bpbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.data_byte   (data_byte),
	.frame_last  (frame_last)
);

### bench/testbench.sv
// self-checking bench for block_projection_bit_extractor
// depends on rtl/bpbe_pkg.sv and rtl/block_projection_bit_extractor.sv
// drives pixel frames under random gaps and stalls and checks every packed block byte

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bpbe_pkg::*;

	localparam int MAX_W          = 2048;
	localparam int MAX_H          = 4096;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PIXELS  = 1200;
	localparam int RANDOM_BYTES   = 48;
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int COS_W8 [8] = '{8035, 6811, 4551, 1598, -1598, -4551, -6811, -8035};
	localparam int COS_W4 [4] = '{7568, 3135, -3135, -7568};

	typedef enum int {
		PAT_RANDOM, PAT_BLACK, PAT_WHITE, PAT_RAMP_UP, PAT_RAMP_DOWN, PAT_SPARSE
	} pattern_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       frame_last;
	} byte_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [7:0]  pixel = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        frame_last;

	// predictor copy of the block state and configuration
	logic        cur_mode;
	logic [11:0] cur_width;
	logic [12:0] cur_height;
	logic [10:0] col_sum [MAX_W];
	int          pcol;
	int          prow;
	logic [27:0] acc;
	logic [7:0]  shifter;
	logic [2:0]  nbits;

	byte_beat_t  expected_bytes [$];

	int idle_pct = 26;
	int stall_pct = 26;
	int mismatches = 0;
	int pixels_sent = 0;
	int frames_done = 0;
	int bytes_predicted = 0;
	int bytes_checked = 0;
	int quiet_cycles = 0;

	block_projection_bit_extractor #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.frame_last  (frame_last)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		byte_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// one pixel through the projection: column sums, weighted accumulate, bit packing
	task automatic project_pixel(input logic [7:0] pix);
		int bsize, weff, heff, bpr, brows, x, y, xr, yr, w, bidx, total;
		logic [10:0] s;
		logic bit_val;
		byte_beat_t beat;
		bsize = cur_mode ? 4 : 8;
		weff = (cur_width > MAX_W) ? MAX_W : int'(cur_width);
		heff = (cur_height > MAX_H) ? MAX_H : int'(cur_height);
		if (weff == 0) weff = 1;
		if (heff == 0) heff = 1;
		bpr = weff / bsize;
		brows = heff / bsize;
		x = pcol;
		y = prow;
		if (x < bpr * bsize && y < brows * bsize && x < MAX_W) begin
			xr = x % bsize;
			yr = y % bsize;
			s = (yr == 0) ? 11'(pix) : col_sum[x] + 11'(pix);
			col_sum[x] = s;
			if (yr == bsize - 1) begin
				w = cur_mode ? COS_W4[xr] : COS_W8[xr];
				acc = acc + 28'(w * int'(s));
				if (xr == bsize - 1) begin
					bit_val = (acc != 0) && !acc[27];
					acc = '0;
					shifter = {shifter[6:0], bit_val};
					nbits = nbits + 3'd1;
					if (nbits == 0) begin
						bidx = (y / bsize) * bpr + x / bsize;
						total = bpr * brows;
						beat.data_byte = shifter;
						beat.frame_last = (bidx + 9 > total);
						expected_bytes.push_back(beat);
						bytes_predicted++;
						shifter = '0;
					end
				end
			end
		end
		if (x + 1 >= weff) begin
			pcol = 0;
			if (y + 1 >= heff) begin
				prow = 0;
				acc = '0;
				shifter = '0;
				nbits = '0;
				frames_done++;
			end else begin
				prow = y + 1;
			end
		end else begin
			pcol = x + 1;
		end
	endtask

	function automatic logic [7:0] pixel_for(input pattern_t pat, input int x);
		logic [7:0] v;
		case (pat)
			PAT_BLACK:     v = 8'd0;
			PAT_WHITE:     v = 8'd255;
			PAT_RAMP_UP:   v = 8'((x % 8) * 36);
			PAT_RAMP_DOWN: v = 8'(255 - (x % 8) * 36);
			PAT_SPARSE:    v = ($urandom_range(7) == 0) ? 8'd255 : 8'd0;
			default:       v = 8'($urandom_range(255));
		endcase
		return v;
	endfunction

	task automatic send_pixel(input logic [7:0] value);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= value;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		project_pixel(value);
		pixels_sent++;
	endtask

	task automatic send_pixels(input pattern_t pat, input int count);
		repeat (count) send_pixel(pixel_for(pat, pcol));
	endtask

	// runs until the frame counters return to the origin
	task automatic send_frame(input pattern_t pat);
		do begin
			send_pixel(pixel_for(pat, pcol));
		end while (pcol != 0 || prow != 0);
	endtask

	task automatic pause_for_results();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
	endtask

	// nothing in flight: all bytes out and the pipeline flushed
	task automatic wait_idle();
		pause_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [12:0] value, input bit last_write);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_BLOCK_MODE:   cur_mode = value[0];
			REG_IMAGE_WIDTH:  cur_width = value[11:0];
			REG_IMAGE_HEIGHT: cur_height = value[12:0];
			default: ;
		endcase
		if (last_write) cfg_we <= 1'b0;
	endtask

	task automatic set_frame(input logic mode, input logic [12:0] w, input logic [12:0] h);
		wait_idle();
		reg_write(REG_BLOCK_MODE, {12'd0, mode}, 1'b0);
		reg_write(REG_IMAGE_WIDTH, w, 1'b0);
		reg_write(REG_IMAGE_HEIGHT, h, 1'b1);
	endtask

	// widest frame first so that every column sum entry holds a written value
	task automatic test_full_width();
		set_frame(1'b0, 13'd4095, 13'd8);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_patterns();
		set_frame(1'b0, 13'd64, 13'd8);
		send_frame(PAT_BLACK);
		send_frame(PAT_WHITE);
		send_frame(PAT_RAMP_UP);
		send_frame(PAT_RAMP_DOWN);
		send_frame(PAT_SPARSE);
		send_frame(PAT_RANDOM);
		set_frame(1'b1, 13'd32, 13'd8);
		send_frame(PAT_RAMP_DOWN);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_partial_bytes();
		set_frame(1'b1, 13'd8, 13'd8);
		send_frame(PAT_RAMP_DOWN);
		set_frame(1'b1, 13'd24, 13'd12);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_ragged_sizes();
		set_frame(1'b0, 13'd70, 13'd17);
		send_frame(PAT_RANDOM);
		set_frame(1'b1, 13'd35, 13'd9);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_degenerate_sizes();
		set_frame(1'b0, 13'd0, 13'd8);
		send_frame(PAT_RANDOM);
		set_frame(1'b0, 13'd16, 13'd0);
		send_frame(PAT_RANDOM);
		set_frame(1'b1, 13'd0, 13'd0);
		reg_write(REG_SPARE, 13'h1fff, 1'b1);
		send_frame(PAT_WHITE);
		set_frame(1'b0, 13'd4, 13'd16);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_tall_frames();
		set_frame(1'b1, 13'd4, 13'd8191);
		send_frame(PAT_RANDOM);
		set_frame(1'b0, 13'd8, 13'd4096);
		send_frame(PAT_RANDOM);
		set_frame(1'b1, 13'd2048, 13'd4);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_mid_frame_write();
		// column counter already past the narrower width
		set_frame(1'b1, 13'd32, 13'd16);
		send_pixels(PAT_RANDOM, 32 * 4 + 20);
		wait_idle();
		reg_write(REG_IMAGE_WIDTH, 13'd16, 1'b1);
		send_frame(PAT_RANDOM);
		// block size switched inside a block row
		set_frame(1'b0, 13'd64, 13'd16);
		send_pixels(PAT_RANDOM, 64 * 3 + 10);
		wait_idle();
		reg_write(REG_BLOCK_MODE, 13'd1, 1'b1);
		send_frame(PAT_RANDOM);
		// row counter already past the shorter height
		set_frame(1'b1, 13'd16, 13'd32);
		send_pixels(PAT_RANDOM, 16 * 9 + 3);
		wait_idle();
		reg_write(REG_IMAGE_HEIGHT, 13'd8, 1'b1);
		send_frame(PAT_RANDOM);
	endtask

	task automatic test_no_idle();
		idle_pct = 0;
		stall_pct = 0;
		set_frame(1'b1, 13'd64, 13'd32);
		send_frame(PAT_RANDOM);
		set_frame(1'b0, 13'd64, 13'd16);
		send_frame(PAT_RANDOM);
		idle_pct = 26;
		stall_pct = 26;
	endtask

	task automatic test_random();
		int start_px, start_bytes, bs;
		logic mode;
		logic [1:0] idx;
		logic [12:0] value;
		pattern_t pat;
		start_px = pixels_sent;
		start_bytes = bytes_predicted;
		while (pixels_sent - start_px < RANDOM_PIXELS ||
				bytes_predicted - start_bytes < RANDOM_BYTES) begin
			mode = $urandom_range(1);
			bs = mode ? 4 : 8;
			if ($urandom_range(7) == 0) begin
				set_frame(mode, 13'($urandom_range(0, 70)), 13'($urandom_range(0, 40)));
			end else begin
				set_frame(mode, 13'(bs * $urandom_range(1, 16)), 13'(bs * $urandom_range(1, 4)));
			end
			pat = ($urandom_range(3) == 0) ? pattern_t'($urandom_range(1, 5)) : PAT_RANDOM;
			case ($urandom_range(5))
				0: begin
					send_pixels(pat, $urandom_range(1, 200));
					pause_for_results();
					send_frame(pat);
				end
				1: begin
					// broken frame: a register is written under way
					send_pixels(pat, $urandom_range(1, 200));
					wait_idle();
					idx = 2'($urandom_range(3));
					case (idx)
						REG_IMAGE_WIDTH:  value = {1'($urandom_range(1)), 12'($urandom_range(0, 80))};
						REG_IMAGE_HEIGHT: value = 13'($urandom_range(0, 40));
						default:          value = 13'($urandom);
					endcase
					reg_write(idx, value, 1'b1);
					send_frame(pat);
				end
				default: send_frame(pat);
			endcase
		end
	endtask

	always @(posedge clk) begin : check_bytes
		byte_beat_t beat;
		if (arst_n && byte_valid && !byte_stall) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", data_byte, frame_last));
			end else begin
				beat = expected_bytes.pop_front();
				if (data_byte !== beat.data_byte)
					report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, beat.data_byte));
				if (frame_last !== beat.frame_last)
					report_mismatch($sformatf("frame_last %0b, want %0b", frame_last, beat.frame_last));
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (byte_valid && !byte_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cur_mode = 1'b0;
		cur_width = WIDTH_RESET;
		cur_height = HEIGHT_RESET;
		pcol = 0;
		prow = 0;
		acc = '0;
		shifter = '0;
		nbits = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_width();
		test_patterns();
		test_partial_bytes();
		test_ragged_sizes();
		test_degenerate_sizes();
		test_tall_frames();
		test_mid_frame_write();
		test_no_idle();
		test_random();

		wait_idle();
		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
		$display("run: %0d pixels, %0d frames, %0d bytes checked, %0d mismatches",
			pixels_sent, frames_done, bytes_checked, mismatches);
		$display("run: 8x8 and 4x4 blocks, clamped and zero sizes, mid-frame writes, stalls");
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
